>>> design/lc3ie_pkg.sv
// Package for the LC-3 instruction execute core.
// Holds transaction types, register file write type and architectural constants.
// Used by the register file, the core and the testbench; depends on nothing.
package lc3ie_pkg;

	localparam int WORD_BITS   = 16;
	localparam int RF_DEPTH    = 8;
	localparam int RF_IDX_BITS = 3;

	localparam logic [WORD_BITS-1:0] PC_RESET = 16'h3000;

	localparam logic [2:0] FLAG_P = 3'b001;
	localparam logic [2:0] FLAG_Z = 3'b010;
	localparam logic [2:0] FLAG_N = 3'b100;

	localparam logic OPN_LOAD = 1'b0;
	localparam logic OPN_EXEC = 1'b1;

	localparam logic [1:0] ST_NORMAL     = 2'd0;
	localparam logic [1:0] ST_TRAP       = 2'd1;
	localparam logic [1:0] ST_BAD_OPCODE = 2'd2;

	typedef enum logic [3:0] {
		OP_BR  = 4'h0, OP_ADD = 4'h1, OP_LD  = 4'h2, OP_ST   = 4'h3,
		OP_JSR = 4'h4, OP_AND = 4'h5, OP_LDR = 4'h6, OP_STR  = 4'h7,
		OP_RTI = 4'h8, OP_NOT = 4'h9, OP_LDI = 4'hA, OP_STI  = 4'hB,
		OP_JMP = 4'hC, OP_RES = 4'hD, OP_LEA = 4'hE, OP_TRAP = 4'hF
	} opcode_t;

	typedef struct packed {
		logic                 operation;
		logic [WORD_BITS-1:0] address;
		logic [WORD_BITS-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic [WORD_BITS-1:0]   program_counter;
		logic [2:0]             condition;
		logic                   reg_written;
		logic [RF_IDX_BITS-1:0] dest_index;
		logic [WORD_BITS-1:0]   dest_value;
		logic                   mem_written;
		logic [WORD_BITS-1:0]   store_address;
		logic [WORD_BITS-1:0]   store_value;
		logic [1:0]             status;
	} rsp_t;

	typedef struct packed {
		logic                   en;
		logic [RF_IDX_BITS-1:0] idx;
		logic [WORD_BITS-1:0]   value;
	} rf_wr_t;

endpackage

>>> design/lc3ie_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Width and depth are parameters; depends on nothing.
module lc3ie_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/lc3ie_regfile.sv
// General register file: two RAM copies give two read ports, valid bits give reset to zero.
// Depends on lc3ie_pkg and lc3ie_ram.
module lc3ie_regfile (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                re,
	input  logic [lc3ie_pkg::RF_IDX_BITS-1:0]   raddr_a,
	input  logic [lc3ie_pkg::RF_IDX_BITS-1:0]   raddr_b,
	output logic [lc3ie_pkg::WORD_BITS-1:0]     rdata_a,
	output logic [lc3ie_pkg::WORD_BITS-1:0]     rdata_b,
	input  lc3ie_pkg::rf_wr_t                   wr
);

	logic [lc3ie_pkg::RF_DEPTH-1:0]  valid_q;
	logic                            a_valid_q;
	logic                            b_valid_q;
	logic [lc3ie_pkg::WORD_BITS-1:0] ram_a;
	logic [lc3ie_pkg::WORD_BITS-1:0] ram_b;

	lc3ie_ram #(
		.WIDTH(lc3ie_pkg::WORD_BITS),
		.DEPTH(lc3ie_pkg::RF_DEPTH)
	) u_ram_a (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.idx),
		.wdata(wr.value),
		.re   (re),
		.raddr(raddr_a),
		.rdata(ram_a)
	);

	lc3ie_ram #(
		.WIDTH(lc3ie_pkg::WORD_BITS),
		.DEPTH(lc3ie_pkg::RF_DEPTH)
	) u_ram_b (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.idx),
		.wdata(wr.value),
		.re   (re),
		.raddr(raddr_b),
		.rdata(ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			a_valid_q <= 1'b0;
			b_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.idx] <= 1'b1;
			end
			if (re) begin
				a_valid_q <= valid_q[raddr_a];
				b_valid_q <= valid_q[raddr_b];
			end
		end
	end

	assign rdata_a = a_valid_q ? ram_a : '0;
	assign rdata_b = b_valid_q ? ram_b : '0;

endmodule

>>> design/lc3_instruction_execute_core.sv
// LC-3 instruction execute core: sequencer around one word memory and the register file.
// Memory loads are taken back to back while the output is free. Instruction: fetch read,
// operand read, execute; LDI and LDR add a step, a further read of the word memory port.
// The result is registered at the end of the last step; a stalled result holds while one
// more transaction is taken. Reset clears PC to 0x3000, CC to Z, registers to 0.
module lc3_instruction_execute_core #(
	parameter int ADDR_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  lc3ie_pkg::cmd_t cmd,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output lc3ie_pkg::rsp_t rsp
);

	localparam int MemWords = 2 ** ADDR_BITS;

	typedef enum logic [2:0] {
		S_IDLE, S_FETCH, S_REG, S_MEM2, S_HOLD
	} state_t;

	state_t          state_q;
	logic [15:0]     pc_q;
	logic [2:0]      cc_q;
	logic [15:0]     ir_q;
	logic            rsp_valid_q;
	lc3ie_pkg::rsp_t rsp_q;
	lc3ie_pkg::rsp_t res_q;
	lc3ie_pkg::rsp_t res_d;

	logic            cmd_acc;
	logic            load_acc;
	logic            exec_acc;
	logic            out_free;

	logic                 mem_we;
	logic [ADDR_BITS-1:0] mem_waddr;
	logic [15:0]          mem_wdata;
	logic                 mem_re;
	logic [ADDR_BITS-1:0] mem_raddr;
	logic [15:0]          mem_rdata;

	logic              rf_re;
	logic [2:0]        rf_raddr_b;
	logic [15:0]       ra;
	logic [15:0]       rb;
	lc3ie_pkg::rf_wr_t rf_wr;

	lc3ie_pkg::opcode_t op_f;
	lc3ie_pkg::opcode_t op;
	logic [2:0]  dr;
	logic [15:0] pc_inc;
	logic [15:0] pcrel_f;
	logic [15:0] pcrel;
	logic [15:0] off6;
	logic [15:0] opb;
	logic [15:0] base_off;

	logic        fin;
	logic        wr;
	logic        cc_en;
	logic [2:0]  dst;
	logic [15:0] val;
	logic [15:0] nxt_pc;
	logic        mw;
	logic [15:0] sa;
	logic [15:0] sv;
	logic [1:0]  st;
	logic [2:0]  flags;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign load_acc  = cmd_acc && (cmd.operation == lc3ie_pkg::OPN_LOAD);
	assign exec_acc  = cmd_acc && (cmd.operation == lc3ie_pkg::OPN_EXEC);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign op_f     = lc3ie_pkg::opcode_t'(mem_rdata[15:12]);
	assign op       = lc3ie_pkg::opcode_t'(ir_q[15:12]);
	assign dr       = ir_q[11:9];
	assign pc_inc   = pc_q + 16'd1;
	assign pcrel_f  = pc_inc + {{7{mem_rdata[8]}}, mem_rdata[8:0]};
	assign pcrel    = pc_inc + {{7{ir_q[8]}}, ir_q[8:0]};
	assign off6     = {{10{ir_q[5]}}, ir_q[5:0]};
	assign opb      = ir_q[5] ? {{11{ir_q[4]}}, ir_q[4:0]} : rb;
	assign base_off = ra + off6;

	// second register port: store source for stores, SR2 otherwise
	always_comb begin
		rf_raddr_b = mem_rdata[2:0];
		unique case (op_f) inside
			lc3ie_pkg::OP_ST, lc3ie_pkg::OP_STI, lc3ie_pkg::OP_STR:
				rf_raddr_b = mem_rdata[11:9];
			default: rf_raddr_b = mem_rdata[2:0];
		endcase
	end

	assign rf_re = (state_q == S_FETCH);

	always_comb begin
		fin    = 1'b0;
		wr     = 1'b0;
		cc_en  = 1'b0;
		dst    = dr;
		val    = '0;
		nxt_pc = pc_inc;
		mw     = 1'b0;
		sa     = '0;
		sv     = '0;
		st     = lc3ie_pkg::ST_NORMAL;
		if (state_q == S_MEM2) begin
			fin   = 1'b1;
			wr    = 1'b1;
			cc_en = 1'b1;
			val   = mem_rdata;
		end else if (state_q == S_REG) begin
			fin = 1'b1;
			unique case (op) inside
				lc3ie_pkg::OP_BR: begin
					if ((dr & cc_q) != 3'b000) begin
						nxt_pc = pcrel;
					end
				end
				lc3ie_pkg::OP_ADD: begin
					wr    = 1'b1;
					cc_en = 1'b1;
					val   = ra + opb;
				end
				lc3ie_pkg::OP_AND: begin
					wr    = 1'b1;
					cc_en = 1'b1;
					val   = ra & opb;
				end
				lc3ie_pkg::OP_NOT: begin
					wr    = 1'b1;
					cc_en = 1'b1;
					val   = ~ra;
				end
				lc3ie_pkg::OP_LD: begin
					wr    = 1'b1;
					cc_en = 1'b1;
					val   = mem_rdata;
				end
				lc3ie_pkg::OP_LDI, lc3ie_pkg::OP_LDR: fin = 1'b0;
				lc3ie_pkg::OP_LEA: begin
					wr    = 1'b1;
					cc_en = 1'b1;
					val   = pcrel;
				end
				lc3ie_pkg::OP_ST: begin
					mw = 1'b1;
					sa = pcrel;
					sv = rb;
				end
				lc3ie_pkg::OP_STI: begin
					mw = 1'b1;
					sa = mem_rdata;
					sv = rb;
				end
				lc3ie_pkg::OP_STR: begin
					mw = 1'b1;
					sa = base_off;
					sv = rb;
				end
				lc3ie_pkg::OP_JMP: nxt_pc = ra;
				lc3ie_pkg::OP_JSR: begin
					wr  = 1'b1;
					dst = 3'd7;
					val = pc_inc;
					nxt_pc = ir_q[11] ? (pc_inc + {{5{ir_q[10]}}, ir_q[10:0]}) : ra;
				end
				lc3ie_pkg::OP_TRAP: st = lc3ie_pkg::ST_TRAP;
				lc3ie_pkg::OP_RTI, lc3ie_pkg::OP_RES: st = lc3ie_pkg::ST_BAD_OPCODE;
			endcase
		end
	end

	always_comb begin
		if (val == 16'd0) begin
			flags = lc3ie_pkg::FLAG_Z;
		end else if (val[15]) begin
			flags = lc3ie_pkg::FLAG_N;
		end else begin
			flags = lc3ie_pkg::FLAG_P;
		end
	end

	always_comb begin
		res_d = '0;
		if (fin) begin
			res_d.program_counter = nxt_pc;
			res_d.condition       = cc_en ? flags : cc_q;
			res_d.reg_written     = wr;
			res_d.dest_index      = wr ? dst : '0;
			res_d.dest_value      = wr ? val : '0;
			res_d.mem_written     = mw;
			res_d.store_address   = sa;
			res_d.store_value     = sv;
			res_d.status          = st;
		end else begin
			res_d.program_counter = pc_q;
			res_d.condition       = cc_q;
		end
	end

	assign rf_wr.en    = fin && wr;
	assign rf_wr.idx   = dst;
	assign rf_wr.value = val;

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = pc_q[ADDR_BITS-1:0];
		unique case (state_q)
			S_IDLE: begin
				mem_re    = exec_acc;
				mem_raddr = pc_q[ADDR_BITS-1:0];
			end
			S_FETCH: begin
				mem_re    = 1'b1;
				mem_raddr = pcrel_f[ADDR_BITS-1:0];
			end
			S_REG: begin
				mem_re    = !fin;
				mem_raddr = (op == lc3ie_pkg::OP_LDI) ? mem_rdata[ADDR_BITS-1:0]
				                                      : base_off[ADDR_BITS-1:0];
			end
			S_MEM2, S_HOLD: begin
				mem_re    = 1'b0;
				mem_raddr = pc_q[ADDR_BITS-1:0];
			end
			default: begin
				mem_re    = 1'b0;
				mem_raddr = pc_q[ADDR_BITS-1:0];
			end
		endcase
	end

	assign mem_we    = load_acc || (mw && (state_q == S_REG));
	assign mem_waddr = load_acc ? cmd.address[ADDR_BITS-1:0] : sa[ADDR_BITS-1:0];
	assign mem_wdata = load_acc ? cmd.data : sv;

	lc3ie_ram #(
		.WIDTH(lc3ie_pkg::WORD_BITS),
		.DEPTH(MemWords)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	lc3ie_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (rf_re),
		.raddr_a(mem_rdata[8:6]),
		.raddr_b(rf_raddr_b),
		.rdata_a(ra),
		.rdata_b(rb),
		.wr     (rf_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= lc3ie_pkg::PC_RESET;
			cc_q        <= lc3ie_pkg::FLAG_Z;
			ir_q        <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			res_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (fin) begin
				pc_q <= nxt_pc;
				if (cc_en) begin
					cc_q <= flags;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (exec_acc) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					ir_q    <= mem_rdata;
					state_q <= S_REG;
				end
				S_REG: begin
					if (!fin) begin
						state_q <= S_MEM2;
					end
				end
				S_MEM2: state_q <= S_IDLE;
				S_HOLD: begin
					if (out_free) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// deliver the result, or hold it until the output register drains
			if (load_acc || fin) begin
				if (out_free) begin
					rsp_q       <= res_d;
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end else begin
					res_q   <= res_d;
					state_q <= S_HOLD;
				end
			end
		end
	end

	a_hold_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD) |-> rsp_valid_q)
		else $error("result held while output register empty");

	a_cc_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(cc_q))
		else $error("condition code not one-hot");

	a_fetch_then_reg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |=> (state_q == S_REG))
		else $error("fetch not followed by operand step");

	a_mem_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == S_IDLE) || (state_q == S_REG)))
		else $error("memory written outside load or execute step");

	a_no_dest_without_write: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.reg_written) |->
		((rsp_q.dest_index == 3'd0) && (rsp_q.dest_value == 16'd0)))
		else $error("destination reported without register write");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for lc3_instruction_execute_core: queued command driver and checking response monitor.
// Expected responses come from an in-bench LC-3 architectural state model; depends on lc3ie_pkg and the core.
module tb;

	localparam int MEM_ADDR_BITS  = 16;
	localparam int MEM_WORDS      = 1 << MEM_ADDR_BITS;
	localparam int ITEM_COUNT     = 1750;
	localparam int HOLDOFF_AT     = 400;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CYCLE_LIMIT    = 1000000;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            cmd_valid = 1'b0;
	logic            cmd_stall;
	lc3ie_pkg::cmd_t cmd       = '0;
	logic            rsp_valid;
	logic            rsp_stall = 1'b0;
	lc3ie_pkg::rsp_t rsp;

	logic [15:0] arch_regs [8] = '{default: 16'h0000};
	logic [15:0] arch_pc       = lc3ie_pkg::PC_RESET;
	logic [2:0]  arch_cc       = lc3ie_pkg::FLAG_Z;
	logic [15:0] arch_mem [MEM_WORDS];
	bit          arch_mem_set [MEM_WORDS];

	lc3ie_pkg::cmd_t cmd_backlog [$];
	lc3ie_pkg::rsp_t rsp_forecast [$];
	lc3ie_pkg::rsp_t rsp_due [$];

	int unsigned items_planned;
	int unsigned items_accepted;
	int unsigned results_seen;
	int unsigned fail_count;
	int unsigned cycle_count;

	int unsigned tx_gap;
	int unsigned tx_calm_left;
	bit          tx_calm;
	bit          send_valid;

	int unsigned     stall_left;
	int unsigned     holdoff_left;
	int unsigned     rx_calm_left;
	bit              rx_calm;
	bit              holdoff_done;
	bit              stall_next;
	lc3ie_pkg::rsp_t rsp_want;

	lc3_instruction_execute_core #(
		.ADDR_BITS(MEM_ADDR_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] sx9(logic [15:0] ir);
		return {{7{ir[8]}}, ir[8:0]};
	endfunction

	function automatic logic [15:0] sx6(logic [15:0] ir);
		return {{10{ir[5]}}, ir[5:0]};
	endfunction

	function automatic logic [15:0] mem_rd(logic [15:0] a);
		return arch_mem[a[MEM_ADDR_BITS-1:0]];
	endfunction

	function automatic void mem_wr(logic [15:0] a, logic [15:0] d);
		arch_mem[a[MEM_ADDR_BITS-1:0]] = d;
		arch_mem_set[a[MEM_ADDR_BITS-1:0]] = 1'b1;
	endfunction

	function automatic logic [15:0] enc(logic [3:0] op, logic [11:0] rest);
		return {op, rest};
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [15:0] random_instr();
		logic [15:0] w;
		w = 16'($urandom);
		if ($urandom_range(0, 1) == 1)
			w[8:0] = 9'($urandom_range(0, 8)) - 9'd4;
		if ($urandom_range(0, 1) == 1)
			w[5:0] = 6'($urandom_range(0, 8)) - 6'd4;
		return w;
	endfunction

	function automatic lc3ie_pkg::rsp_t retire_item(lc3ie_pkg::cmd_t c);
		lc3ie_pkg::rsp_t r;
		logic [15:0]     ir, pc, pcrel, val, ea;
		logic [3:0]      op;
		logic [2:0]      dr, r1;
		logic            wr, set_cc;
		r = '0;
		if (c.operation == lc3ie_pkg::OPN_LOAD) begin
			mem_wr(c.address, c.data);
		end else begin
			ir = mem_rd(arch_pc);
			pc = arch_pc + 16'd1;
			op = ir[15:12];
			dr = ir[11:9];
			r1 = ir[8:6];
			pcrel = pc + sx9(ir);
			wr = 1'b0;
			set_cc = 1'b1;
			val = '0;
			case (op)
			lc3ie_pkg::OP_BR: begin
				if ((dr & arch_cc) != 3'b000)
					pc = pcrel;
			end
			lc3ie_pkg::OP_ADD, lc3ie_pkg::OP_AND: begin
				ea = ir[5] ? {{11{ir[4]}}, ir[4:0]} : arch_regs[ir[2:0]];
				val = (op == lc3ie_pkg::OP_ADD) ? arch_regs[r1] + ea : arch_regs[r1] & ea;
				wr = 1'b1;
			end
			lc3ie_pkg::OP_LD: begin
				val = mem_rd(pcrel);
				wr = 1'b1;
			end
			lc3ie_pkg::OP_LDI: begin
				val = mem_rd(mem_rd(pcrel));
				wr = 1'b1;
			end
			lc3ie_pkg::OP_LDR: begin
				val = mem_rd(arch_regs[r1] + sx6(ir));
				wr = 1'b1;
			end
			lc3ie_pkg::OP_LEA: begin
				val = pcrel;
				wr = 1'b1;
			end
			lc3ie_pkg::OP_NOT: begin
				val = ~arch_regs[r1];
				wr = 1'b1;
			end
			lc3ie_pkg::OP_ST, lc3ie_pkg::OP_STI, lc3ie_pkg::OP_STR: begin
				if (op == lc3ie_pkg::OP_ST)
					ea = pcrel;
				else if (op == lc3ie_pkg::OP_STI)
					ea = mem_rd(pcrel);
				else
					ea = arch_regs[r1] + sx6(ir);
				mem_wr(ea, arch_regs[dr]);
				r.mem_written = 1'b1;
				r.store_address = ea;
				r.store_value = arch_regs[dr];
			end
			lc3ie_pkg::OP_JMP: begin
				pc = arch_regs[r1];
			end
			lc3ie_pkg::OP_JSR: begin
				ea = ir[11] ? pc + {{5{ir[10]}}, ir[10:0]} : arch_regs[r1];
				val = pc;
				dr = 3'd7;
				wr = 1'b1;
				set_cc = 1'b0;
				pc = ea;
			end
			lc3ie_pkg::OP_TRAP: begin
				r.status = lc3ie_pkg::ST_TRAP;
			end
			default: begin
				r.status = lc3ie_pkg::ST_BAD_OPCODE;
			end
			endcase
			if (wr) begin
				arch_regs[dr] = val;
				if (set_cc)
					arch_cc = (val == 16'h0000) ? lc3ie_pkg::FLAG_Z :
						(val[15] ? lc3ie_pkg::FLAG_N : lc3ie_pkg::FLAG_P);
				r.reg_written = 1'b1;
				r.dest_index = dr;
				r.dest_value = val;
			end
			arch_pc = pc;
		end
		r.program_counter = arch_pc;
		r.condition = arch_cc;
		return r;
	endfunction

	task automatic queue_item(logic opn, logic [15:0] a, logic [15:0] d);
		lc3ie_pkg::cmd_t c;
		c.operation = opn;
		c.address = a;
		c.data = d;
		cmd_backlog.push_back(c);
		rsp_forecast.push_back(retire_item(c));
	endtask

	task automatic ensure_word(logic [15:0] a);
		if (!arch_mem_set[a[MEM_ADDR_BITS-1:0]])
			queue_item(lc3ie_pkg::OPN_LOAD, a, 16'($urandom));
	endtask

	// Load the instruction if asked or if the fetch word is unwritten, back its operands, execute.
	task automatic plan_exec(bit rewrite, logic [15:0] word);
		logic [15:0] ir, ea;
		if (rewrite || !arch_mem_set[arch_pc[MEM_ADDR_BITS-1:0]])
			queue_item(lc3ie_pkg::OPN_LOAD, arch_pc, word);
		ir = mem_rd(arch_pc);
		ea = arch_pc + 16'd1 + sx9(ir);
		if (ir[15:12] == lc3ie_pkg::OP_LDR)
			ea = arch_regs[ir[8:6]] + sx6(ir);
		if (ir[15:12] inside {lc3ie_pkg::OP_LD, lc3ie_pkg::OP_LDI, lc3ie_pkg::OP_STI,
				lc3ie_pkg::OP_LDR})
			ensure_word(ea);
		if (ir[15:12] == lc3ie_pkg::OP_LDI)
			ensure_word(mem_rd(ea));
		queue_item(lc3ie_pkg::OPN_EXEC, 16'($urandom), 16'($urandom));
	endtask

	task automatic note_field(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, field, want, got);
			fail_count++;
		end
	endtask

	initial begin
		int unsigned roll;
		queue_item(lc3ie_pkg::OPN_LOAD, 16'hFFFF, 16'hFFFF);
		queue_item(lc3ie_pkg::OPN_LOAD, 16'h0000, 16'h0000);
		plan_exec(1'b1, enc(lc3ie_pkg::OP_ADD, 12'h23F));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_ADD, 12'h641));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_AND, 12'h860));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_AND, 12'hA43));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_NOT, 12'hD3F));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_BR, 12'h1FF));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_BR, 12'h8FF));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_LD, 12'hF00));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_LDI, 12'h0FF));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_LDR, 12'h460));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_LDR, 12'h65F));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_LEA, 12'h9FF));
		// store onto the next fetch word, then run what was stored
		plan_exec(1'b1, enc(lc3ie_pkg::OP_ST, 12'h200));
		plan_exec(1'b0, '0);
		plan_exec(1'b1, enc(lc3ie_pkg::OP_STI, 12'hA01));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_STR, 12'hC60));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_RTI, 12'h000));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_RES, 12'h000));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_JSR, 12'hC00));
		plan_exec(1'b1, enc(lc3ie_pkg::OP_JSR, 12'h1C0));
		// jump to the top word, wrap the counter past it, return
		plan_exec(1'b1, enc(lc3ie_pkg::OP_JMP, 12'h040));
		plan_exec(1'b0, '0);
		plan_exec(1'b1, enc(lc3ie_pkg::OP_JMP, 12'h1C0));
		while (cmd_backlog.size() < ITEM_COUNT) begin
			roll = $urandom_range(0, 99);
			if (roll < 8)
				queue_item(lc3ie_pkg::OPN_LOAD, 16'($urandom), 16'($urandom));
			else
				plan_exec(roll < 30, random_instr());
		end
		items_planned = cmd_backlog.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (items_accepted != items_planned)
			@(posedge clk);
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			send_valid = cmd_valid;
			if (cmd_valid && !cmd_stall) begin
				rsp_due.push_back(rsp_forecast.pop_front());
				items_accepted++;
				send_valid = 1'b0;
			end
			if (!send_valid) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (cmd_backlog.size() != 0) begin
					cmd <= cmd_backlog.pop_front();
					send_valid = 1'b1;
					if (tx_calm_left == 0) begin
						tx_calm = ($urandom_range(0, 3) == 0);
						tx_calm_left = $urandom_range(20, 80);
					end
					tx_calm_left--;
					tx_gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
				end
			end
			cmd_valid <= send_valid;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (rsp_due.size() == 0) begin
					$display("%0t: response expected none actual %h", $time, rsp);
					fail_count++;
				end else begin
					rsp_want = rsp_due.pop_front();
					note_field("program_counter", rsp_want.program_counter, rsp.program_counter);
					note_field("condition", rsp_want.condition, rsp.condition);
					note_field("reg_written", rsp_want.reg_written, rsp.reg_written);
					note_field("dest_index", rsp_want.dest_index, rsp.dest_index);
					note_field("dest_value", rsp_want.dest_value, rsp.dest_value);
					note_field("mem_written", rsp_want.mem_written, rsp.mem_written);
					note_field("store_address", rsp_want.store_address, rsp.store_address);
					note_field("store_value", rsp_want.store_value, rsp.store_value);
					note_field("status", rsp_want.status, rsp.status);
					results_seen++;
				end
			end
			if (rx_calm_left == 0) begin
				rx_calm = ($urandom_range(0, 3) == 0);
				rx_calm_left = $urandom_range(50, 300);
			end
			rx_calm_left--;
			// hold off once for a long stretch so the core backs up into its input
			if (holdoff_left > 0) begin
				stall_next = 1'b1;
				holdoff_left--;
			end else if (results_seen >= HOLDOFF_AT && !holdoff_done) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_CYCLES;
				stall_next = 1'b1;
			end else if (stall_left > 0) begin
				stall_next = 1'b1;
				stall_left--;
			end else begin
				stall_next = 1'b0;
				if (!rx_calm && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
			rsp_stall <= stall_next;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule
